@@ rtl/bdq_pkg.sv @@
// Package for the bounded double-ended queue: payload structs, opcodes,
// status codes and the command/status structs between controller and datapath.
// No dependencies.
package bdq_pkg;

   localparam int DEPTH_DEFAULT = 32;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_LIST_FWD   = 3'd4;
   localparam logic [2:0] OP_LIST_REV   = 3'd5;

   localparam logic [1:0] STS_OK    = 2'd0;
   localparam logic [1:0] STS_EMPTY = 2'd1;
   localparam logic [1:0] STS_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] element;
      logic               last;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic       push_front;
      logic       push_back;
      logic       pop_front;
      logic       pop_back;
      logic       list_start;
      logic       list_rev;
      logic       list_next;
      logic       rsp_load;
      logic       rsp_from_mem;
      logic [1:0] rsp_status;
      logic       rsp_last;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic empty;
      logic full;
      logic list_last;
      logic rsp_free;
   } stat_type;

endpackage

@@ rtl/bdq_ctrl.sv @@
// Controller state machine for the bounded double-ended queue.
// Decodes transactions and sequences pops and listings. Depends on bdq_pkg.
module bdq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        opcode,
   input  bdq_pkg::stat_type stat,
   output bdq_pkg::cmd_type  cmd
);
   import bdq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_LIST
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = stat.rsp_free;
            if (req_valid && stat.rsp_free) begin
               case (opcode)
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_last = 1'b1;
                     if (stat.full) begin
                        cmd.rsp_status = STS_FULL;
                     end else begin
                        cmd.rsp_status = STS_OK;
                        cmd.push_front = (opcode == OP_PUSH_FRONT);
                        cmd.push_back  = (opcode == OP_PUSH_BACK);
                     end
                  end
                  OP_POP_FRONT, OP_POP_BACK: begin
                     if (stat.empty) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_last   = 1'b1;
                        cmd.rsp_status = STS_EMPTY;
                     end else begin
                        // read issued now, data lands next cycle
                        cmd.pop_front = (opcode == OP_POP_FRONT);
                        cmd.pop_back  = (opcode == OP_POP_BACK);
                        state_in      = ST_POP;
                     end
                  end
                  OP_LIST_FWD, OP_LIST_REV: begin
                     if (stat.empty) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_last   = 1'b1;
                        cmd.rsp_status = STS_EMPTY;
                     end else begin
                        cmd.list_start = 1'b1;
                        cmd.list_rev   = (opcode == OP_LIST_REV);
                        state_in       = ST_LIST;
                     end
                  end
                  default: begin
                     // unused opcode: drop the transaction
                  end
               endcase
            end
         end
         ST_POP: begin
            // output register was free at accept and nothing loaded since
            cmd.rsp_load     = 1'b1;
            cmd.rsp_from_mem = 1'b1;
            cmd.rsp_status   = STS_OK;
            cmd.rsp_last     = 1'b1;
            state_in         = ST_IDLE;
         end
         ST_LIST: begin
            if (stat.rsp_free) begin
               cmd.rsp_load     = 1'b1;
               cmd.rsp_from_mem = 1'b1;
               cmd.rsp_status   = STS_OK;
               cmd.rsp_last     = stat.list_last;
               if (stat.list_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.list_next = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_pop_then_result: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop_front || cmd.pop_back) |=> (cmd.rsp_load && cmd.rsp_from_mem))
      else $error("pop did not deliver its result in the following cycle");

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == ST_IDLE && stat.rsp_free))
      else $error("ready raised outside idle or with output occupied");
`endif

endmodule

@@ rtl/bdq_datapath.sv @@
// Datapath for the bounded double-ended queue: ring store, front index,
// element count, listing counter and result register. Depends on bdq_pkg.
module bdq_datapath #(
   parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic signed [31:0] push_value,
   input  bdq_pkg::cmd_type   cmd,
   output bdq_pkg::stat_type  stat,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output bdq_pkg::rsp_type   rsp_data
);
   import bdq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W:0]   SUM_DEPTH = (IDX_W + 1)'(DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b);
      logic [IDX_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= SUM_DEPTH) begin
         sum = sum - SUM_DEPTH;
      end
      return sum[IDX_W-1:0];
   endfunction

   logic signed [31:0] ring_mem [DEPTH];
   logic signed [31:0] rd_data_ff;

   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] lst_idx_ff, lst_idx_in;
   logic             lst_rev_ff, lst_rev_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [IDX_W-1:0] front_dec, front_inc, back_off, lst_off;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic             rd_en, wr_en;

   assign front_dec = (front_ff == '0) ? LAST_IDX : front_ff - IDX_W'(1);
   assign front_inc = (front_ff == LAST_IDX) ? '0 : front_ff + IDX_W'(1);
   assign back_off  = IDX_W'(count_ff - CNT_W'(1));

   assign lst_idx_in = cmd.list_start ? '0 :
                       cmd.list_next  ? lst_idx_ff + IDX_W'(1) : lst_idx_ff;
   assign lst_rev_in = cmd.list_start ? cmd.list_rev : lst_rev_ff;
   assign lst_off    = lst_rev_in ? back_off - lst_idx_in : lst_idx_in;

   assign rd_en   = cmd.pop_front || cmd.pop_back || cmd.list_start || cmd.list_next;
   assign rd_addr = cmd.pop_front ? front_ff :
                    cmd.pop_back  ? wrap_add(front_ff, back_off) :
                                    wrap_add(front_ff, lst_off);

   assign wr_en   = cmd.push_front || cmd.push_back;
   assign wr_addr = cmd.push_front ? front_dec : wrap_add(front_ff, IDX_W'(count_ff));

   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      if (cmd.push_front) begin
         front_in = front_dec;
      end else if (cmd.pop_front) begin
         front_in = front_inc;
      end
      if (wr_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop_front || cmd.pop_back) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_in.status  = cmd.rsp_status;
         rsp_in.element = cmd.rsp_from_mem ? rd_data_ff : 32'sd0;
         rsp_in.last    = cmd.rsp_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= push_value;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         lst_idx_ff   <= '0;
         lst_rev_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         lst_idx_ff   <= lst_idx_in;
         lst_rev_ff   <= lst_rev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ff == FULL_CNT);
   assign stat.list_last = ((CNT_W'(lst_idx_ff) + CNT_W'(1)) == count_ff);
   assign stat.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("element count above capacity");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_front || cmd.push_back) |-> (count_ff != FULL_CNT))
      else $error("push issued on a full queue");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop_front || cmd.pop_back || cmd.list_start) |-> (count_ff != '0))
      else $error("read issued on an empty queue");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while held");
`endif

endmodule

@@ rtl/bounded_double_ended_queue.sv @@
// Bounded double-ended queue of signed 32-bit values; uses bdq_pkg,
// bdq_ctrl and bdq_datapath.
//
// Requests come in on req_* (valid/ready, payload req_data: opcode and value),
// results leave on rsp_* (valid/ready, payload rsp_data: status, element,
// last). A push or any error answers with one result, loaded into the result
// register as the transaction is taken; a push can be taken every cycle while
// rsp_ready stays high. A pop reads the ring store into the read register,
// then the pop state loads the result from it; the next request waits for idle.
// A listing of N elements reads its first element as it is taken, then gives
// its N results, one per cycle while the result register is free; the single
// ring store read port sets that pace. Requests are held off throughout.
// When the receiver stalls, the result register holds and the queue takes no
// new request until that result is taken. Reset empties the queue at once
// (front index and count cleared); the store contents are not cleared.
module bounded_double_ended_queue #(
   parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bdq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bdq_pkg::rsp_type rsp_data
);
   import bdq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .opcode    (req_data.opcode),
      .stat      (stat),
      .cmd       (cmd)
   );

   bdq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .push_value (req_data.value),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

@@ test/bounded_double_ended_queue_test.sv @@
// Self-checking bench for bounded_double_ended_queue: directed and random deque
// traffic, with a shadow deque that predicts every result and checks each field.
// Depends on bdq_pkg and the bounded_double_ended_queue RTL.
module bounded_double_ended_queue_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bdq_pkg::*;

   localparam int         DEPTH        = DEPTH_DEFAULT;
   localparam logic [2:0] OP_SPARE_6   = 3'd6;
   localparam logic [2:0] OP_SPARE_7   = 3'd7;
   localparam int         RANDOM_ITEMS = 100;
   localparam int         HOLD_AFTER   = 50;
   localparam int         HOLD_CYCLES  = 300;
   localparam int         SETTLE_CYCLES = 80;
   localparam int         CYCLE_LIMIT  = 400000;
   localparam int         REPORT_MAX   = 10;

   typedef enum logic [1:0] {PH_FILL, PH_DRAIN, PH_MIXED} phase_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   bounded_double_ended_queue u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------- stimulus
   req_type pending_reqs[$];
   int      gen_count    = 0;
   int      useful_items = 0;

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [2:0] pick_push();
      return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
   endfunction

   function automatic logic [2:0] pick_pop();
      return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
   endfunction

   function automatic logic [2:0] pick_list();
      return $urandom_range(0, 1) ? OP_LIST_REV : OP_LIST_FWD;
   endfunction

   function automatic logic [2:0] pick_mixed_op();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40)
         return pick_push();
      else if (roll < 75)
         return pick_pop();
      else if (roll < 94)
         return pick_list();
      else
         return $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
   endfunction

   // Track only the occupancy so the generator can steer toward full and empty.
   function automatic void queue_req(logic [2:0] op, logic [31:0] val);
      req_type r;
      r.opcode = op;
      r.value  = val;
      pending_reqs.push_back(r);
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: if (gen_count < DEPTH) gen_count++;
         OP_POP_FRONT, OP_POP_BACK:   if (gen_count > 0) gen_count--;
         default: ;
      endcase
      if (op <= OP_LIST_REV)
         useful_items++;
   endfunction

   // ------------------------------------------------------------- predictor
   logic signed [31:0] shadow_store [DEPTH];
   logic [4:0]         shadow_front;
   logic [5:0]         shadow_count;
   rsp_type            rsp_expected[$];

   int requests_seen   = 0;
   int listings_seen   = 0;
   int refused_pushes  = 0;
   int empty_replies   = 0;
   int peak_depth      = 0;
   int results_checked = 0;
   int mismatches      = 0;

   function automatic void expect_rsp(logic [1:0] st, logic signed [31:0] el, logic lst);
      rsp_type r;
      r.status  = st;
      r.element = el;
      r.last    = lst;
      rsp_expected.push_back(r);
   endfunction

   function automatic void deque_apply(req_type t);
      logic [4:0] slot;
      int         off;
      requests_seen++;
      case (t.opcode)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (shadow_count == DEPTH) begin
               expect_rsp(STS_FULL, '0, 1'b1);
               refused_pushes++;
            end else begin
               if (t.opcode == OP_PUSH_FRONT) begin
                  shadow_front = shadow_front - 5'd1;
                  slot = shadow_front;
               end else begin
                  slot = shadow_front + shadow_count[4:0];
               end
               shadow_store[slot] = t.value;
               shadow_count++;
               if (shadow_count > peak_depth)
                  peak_depth = shadow_count;
               expect_rsp(STS_OK, '0, 1'b1);
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (shadow_count == 0) begin
               expect_rsp(STS_EMPTY, '0, 1'b1);
               empty_replies++;
            end else begin
               if (t.opcode == OP_POP_FRONT) begin
                  expect_rsp(STS_OK, shadow_store[shadow_front], 1'b1);
                  shadow_front = shadow_front + 5'd1;
               end else begin
                  slot = shadow_front + shadow_count[4:0] - 5'd1;
                  expect_rsp(STS_OK, shadow_store[slot], 1'b1);
               end
               shadow_count--;
            end
         end
         OP_LIST_FWD, OP_LIST_REV: begin
            listings_seen++;
            if (shadow_count == 0) begin
               expect_rsp(STS_EMPTY, '0, 1'b1);
               empty_replies++;
            end else begin
               for (int i = 0; i < shadow_count; i++) begin
                  off  = (t.opcode == OP_LIST_FWD) ? i : shadow_count - 1 - i;
                  slot = shadow_front + off[4:0];
                  expect_rsp(STS_OK, shadow_store[slot], i == shadow_count - 1);
               end
            end
         end
         default: ;  // spare opcodes are dropped without a result
      endcase
   endfunction

   function automatic void log_mismatch(string what, rsp_type want, rsp_type got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("[%0t] %s: expected st=%0d el=%0d last=%0d, got st=%0d el=%0d last=%0d",
                  $time, what, want.status, $signed(want.element), want.last,
                  got.status, $signed(got.element), got.last);
   endfunction

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin : driver
      int   gap_left;
      logic tx_burst;
      logic offering;
      if (reset) begin
         gap_left = 0;
         tx_burst = 1'b0;
         req_valid <= 1'b0;
      end else begin
         offering = req_valid;
         if (req_valid && req_ready) begin
            offering = 1'b0;
            if ($urandom_range(0, 15) == 0)
               tx_burst = !tx_burst;
            gap_left = tx_burst ? 0 : $urandom_range(0, 7);
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_reqs.size() > 0) begin
               req_data <= pending_reqs.pop_front();
               offering = 1'b1;
            end
         end
         req_valid <= offering;
      end
   end

   // Long receiver hold-off once, so the block backs up and stalls its input.
   int   hold_left;
   int   hold_seen;
   logic hold_armed;

   always @(posedge clock) begin : receiver_hold
      if (reset) begin
         hold_left  <= 0;
         hold_seen  <= 0;
         hold_armed <= 1'b1;
      end else begin
         if (req_valid && req_ready)
            hold_seen <= hold_seen + 1;
         if (hold_armed && hold_seen == HOLD_AFTER) begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end
      end
   end

   // --------------------------------------------------------------- monitor
   always @(posedge clock) begin : monitor
      rsp_type want;
      int      stall_left;
      logic    rx_burst;
      if (reset) begin
         shadow_front = '0;
         shadow_count = '0;
         stall_left   = 0;
         rx_burst     = 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         // Check results before predicting: a result never stems from a
         // transaction taken on the same edge.
         if (rsp_valid && rsp_ready) begin
            if (rsp_expected.size() == 0) begin
               log_mismatch("result with nothing pending", '0, rsp_data);
            end else begin
               want = rsp_expected.pop_front();
               results_checked++;
               if (rsp_data.status !== want.status || rsp_data.element !== want.element ||
                   rsp_data.last !== want.last)
                  log_mismatch("result mismatch", want, rsp_data);
            end
            if ($urandom_range(0, 15) == 0)
               rx_burst = !rx_burst;
            stall_left = rx_burst ? 0 : $urandom_range(0, 7);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         if (req_valid && req_ready)
            deque_apply(req_data);
         rsp_ready <= (stall_left == 0) && (hold_left == 0);
      end
   end

   // -------------------------------------------------------------- watchdog
   int cycle_count = 0;

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still outstanding",
                  cycle_count, rsp_expected.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ------------------------------------------------------- sequence + end
   initial begin : stimulus
      phase_type kind;
      int        round;
      int        directed_items;

      // Empty queue: every pop and listing reports empty; spare opcodes vanish.
      queue_req(OP_POP_FRONT, $urandom);
      queue_req(OP_POP_BACK, $urandom);
      queue_req(OP_LIST_FWD, $urandom);
      queue_req(OP_LIST_REV, $urandom);
      queue_req(OP_SPARE_6, $urandom);
      queue_req(OP_SPARE_7, $urandom);
      // Extreme values from both ends, front index wraps below zero.
      queue_req(OP_PUSH_BACK, 32'h7fff_ffff);
      queue_req(OP_PUSH_FRONT, 32'h8000_0000);
      queue_req(OP_PUSH_BACK, 32'h0000_0000);
      queue_req(OP_PUSH_FRONT, 32'hffff_ffff);
      queue_req(OP_PUSH_BACK, 32'h5555_5555);
      queue_req(OP_PUSH_FRONT, 32'haaaa_aaaa);
      queue_req(OP_LIST_FWD, $urandom);
      queue_req(OP_LIST_REV, $urandom);
      queue_req(OP_POP_FRONT, $urandom);
      queue_req(OP_POP_BACK, $urandom);
      queue_req(OP_LIST_FWD, $urandom);
      queue_req(OP_POP_FRONT, $urandom);
      queue_req(OP_POP_BACK, $urandom);
      queue_req(OP_POP_FRONT, $urandom);
      queue_req(OP_POP_BACK, $urandom);
      queue_req(OP_POP_BACK, $urandom);
      directed_items = useful_items;

      // Random phases: fill to full and beyond, drain to empty and beyond, mix.
      round = 0;
      while (useful_items - directed_items < RANDOM_ITEMS) begin
         if (round == 0)
            kind = PH_FILL;
         else if (round == 1)
            kind = PH_DRAIN;
         else
            kind = phase_type'($urandom_range(0, 2));
         case (kind)
            PH_FILL: begin
               while (gen_count < DEPTH)
                  queue_req(pick_push(), pick_value());
               repeat ($urandom_range(1, 3))
                  queue_req(pick_push(), pick_value());
               if ($urandom_range(0, 1))
                  queue_req(pick_list(), $urandom);
            end
            PH_DRAIN: begin
               while (gen_count > 0)
                  queue_req(pick_pop(), $urandom);
               queue_req($urandom_range(0, 1) ? pick_pop() : pick_list(), $urandom);
            end
            default: begin
               repeat ($urandom_range(8, 16))
                  queue_req(pick_mixed_op(), pick_value());
            end
         endcase
         round++;
      end

      @(negedge clock);
      while (reset || pending_reqs.size() > 0 || req_valid)
         @(negedge clock);
      while (rsp_expected.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("covered %0d requests: %0d listings, %0d refused pushes, %0d empty replies",
               requests_seen, listings_seen, refused_pushes, empty_replies);
      $display("checked %0d results, peak occupancy %0d of %0d, %0d mismatches",
               results_checked, peak_depth, DEPTH, mismatches);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/bdq_pkg.sv
rtl/bdq_ctrl.sv
rtl/bdq_datapath.sv
rtl/bounded_double_ended_queue.sv
test/bounded_double_ended_queue_test.sv
